### hw/rtl/dqff_pkg.sv
package dqff_pkg;

    localparam int POS_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] POS_MAX = 7'd127;
    localparam logic [POS_W-1:0] TYPE_POS = 7'd12;
    localparam logic [POS_W-1:0] IHL_POS = 7'd14;
    localparam logic [POS_W-1:0] PROTO_POS = 7'd23;
    localparam logic [POS_W-1:0] PORT_OFS = 7'd2;
    localparam logic [POS_W-1:0] COUNT_OFS = 7'd12;
    localparam logic [7:0] IHL_MASK = 8'h0f;

    localparam logic [CFG_IDX_W-1:0] CFG_ETHERTYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT = 2'd2;

    localparam logic [15:0] RST_ETHERTYPE = 16'h0800;
    localparam logic [7:0] RST_PROTOCOL = 8'h11;
    localparam logic [15:0] RST_PORT = 16'd53;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       ingress_port;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic drop;
        logic egress_port;
    } t_out_item;

    typedef struct packed {
        logic [15:0] match_ethertype;
        logic [7:0]  match_protocol;
        logic [15:0] match_port;
    } t_cfg;

endpackage

### hw/rtl/dqff_stream_if.sv
interface dqff_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

### hw/rtl/dqff_cfg_regs.sv
module dqff_cfg_regs
    import dqff_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_ethertype <= RST_ETHERTYPE;
            r_cfg.match_protocol  <= RST_PROTOCOL;
            r_cfg.match_port      <= RST_PORT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ETHERTYPE: begin
                    r_cfg.match_ethertype <= i_cfg_data;
                end
                CFG_PROTOCOL: begin
                    r_cfg.match_protocol <= i_cfg_data[7:0];
                end
                CFG_PORT: begin
                    r_cfg.match_port <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/dqff_parser.sv
module dqff_parser
    import dqff_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_verdict
);

    logic [POS_W-1:0] r_pos,        n_pos;
    logic [7:0]       r_type_hi,    n_type_hi;
    logic             r_type_match, n_type_match;
    logic [3:0]       r_hw,         n_hw;
    logic             r_proto,      n_proto;
    logic [7:0]       r_port_hi,    n_port_hi;
    logic             r_port_match, n_port_match;
    logic [7:0]       r_count_hi,   n_count_hi;
    logic             r_query,      n_query;
    logic [POS_W-1:0] w_udp;
    logic             w_drop;
    logic [7:0]       w_byte;

    assign w_byte = i_item.frame_byte;
    assign w_udp  = IHL_POS + {1'b0, r_hw, 2'b00};

    always_comb begin
        n_pos        = r_pos;
        n_type_hi    = r_type_hi;
        n_type_match = r_type_match;
        n_hw         = r_hw;
        n_proto      = r_proto;
        n_port_hi    = r_port_hi;
        n_port_match = r_port_match;
        n_count_hi   = r_count_hi;
        n_query      = r_query;

        if (r_pos == TYPE_POS) begin
            n_type_hi = w_byte;
        end
        if (r_pos == TYPE_POS + 7'd1) begin
            n_type_match = ({r_type_hi, w_byte} == i_cfg.match_ethertype);
        end
        if (r_pos == IHL_POS) begin
            n_hw = 4'(w_byte & IHL_MASK);
        end
        if (r_pos == PROTO_POS) begin
            n_proto = (w_byte == i_cfg.match_protocol);
        end
        if (r_pos > IHL_POS) begin
            if (r_pos == w_udp + PORT_OFS) begin
                n_port_hi = w_byte;
            end
            if (r_pos == w_udp + PORT_OFS + 7'd1) begin
                n_port_match = ({r_port_hi, w_byte} == i_cfg.match_port);
            end
            if (r_pos == w_udp + COUNT_OFS) begin
                n_count_hi = w_byte;
            end
            if (r_pos == w_udp + COUNT_OFS + 7'd1) begin
                n_query = ((r_count_hi | w_byte) != 8'd0);
            end
        end
        if (r_pos != POS_MAX) begin
            n_pos = r_pos + 7'd1;
        end

        w_drop = n_type_match & n_proto & n_port_match & n_query;

        if (i_item.frame_end) begin
            n_pos        = '0;
            n_type_hi    = '0;
            n_type_match = 1'b0;
            n_hw         = '0;
            n_proto      = 1'b0;
            n_port_hi    = '0;
            n_port_match = 1'b0;
            n_count_hi   = '0;
            n_query      = 1'b0;
        end
    end

    assign o_verdict.drop        = w_drop;
    assign o_verdict.egress_port = w_drop ? 1'b0 : ~i_item.ingress_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_type_hi    <= '0;
            r_type_match <= 1'b0;
            r_hw         <= '0;
            r_proto      <= 1'b0;
            r_port_hi    <= '0;
            r_port_match <= 1'b0;
            r_count_hi   <= '0;
            r_query      <= 1'b0;
        end else if (i_step) begin
            r_pos        <= n_pos;
            r_type_hi    <= n_type_hi;
            r_type_match <= n_type_match;
            r_hw         <= n_hw;
            r_proto      <= n_proto;
            r_port_hi    <= n_port_hi;
            r_port_match <= n_port_match;
            r_count_hi   <= n_count_hi;
            r_query      <= n_query;
        end
    end

endmodule

### hw/rtl/dns_query_frame_filter_core.sv
// Byte-serial DNS query filter: takes one Ethernet frame byte per item and
// gives one verdict item (drop, or forward to the other port) on the byte
// marked as the end of the frame. It accepts one item every clock cycle
// unless an end-of-frame item waits for a full output register; each item
// is held in an input register while the header field parser updates its
// state, and the output register takes the verdict as the end-of-frame
// item advances. The match registers should only be written between frames.
module dns_query_frame_filter_core
    import dqff_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dqff_stream_if.sink           i_in,
    dqff_stream_if.source         o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      w_cfg;
    t_out_item w_verdict;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_out_free;
    logic      w_advance;

    dqff_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    dqff_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_item    (r_in_item),
        .i_cfg     (w_cfg),
        .o_verdict (w_verdict)
    );

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_advance  = r_in_valid && (!r_in_item.frame_end || w_out_free);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_item.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_item.frame_end) begin
            r_out_item <= w_verdict;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    a_end_waits_for_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_item.frame_end && r_out_valid && !o_out.ready |=> r_in_valid)
        else $error("end-of-frame item left the input register while the output was full");

    a_drop_has_no_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.drop |-> !r_out_item.egress_port)
        else $error("dropped frame carries a forwarding port");

    a_verdict_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && r_in_item.frame_end))
        else $error("verdict appeared without an end-of-frame item");

endmodule
